>>> hw/rtl/nmea_rmc_sentence_parser_assert.svh
// Assertion macros shared by the RMC parser RTL.
// Needs nothing else; files that check their logic include it by name.
`ifndef NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH
`define NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NRMC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NRMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/nrmc_pkg.sv
// Shared types, codes and constants for the RMC sentence parser.
// No dependencies; imported by nrmc_parse and the top level.
package nrmc_pkg;

    localparam int MINUTE_FRACTION_DIGITS_DEF = 4;
    localparam int SPEED_FRACTION_DIGITS_DEF  = 3;
    localparam int FIELD_COUNT                = 13;

    localparam logic [3:0] LAST_FIELD = 4'(FIELD_COUNT - 1);

    // field indexes within the sentence
    localparam logic [3:0] FLD_HEADER = 4'd0;
    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_NS     = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_SPEED  = 4'd7;
    localparam logic [3:0] FLD_DATE   = 4'd9;

    // characters
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_E     = 8'h45;

    // "$GPRMC"
    localparam logic [7:0] HDR_TEXT [0:5] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

    localparam logic [23:0] POW10_TAB [0:7] = '{
        24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000,
        24'd10000000
    };

    // fix status codes
    localparam logic [1:0] FIX_VALID  = 2'd0;
    localparam logic [1:0] FIX_VOID   = 2'd1;
    localparam logic [1:0] FIX_REJECT = 2'd2;

    // result widths
    localparam int LAT_W       = 28;
    localparam int LON_W       = 31;
    localparam int SPEED_W     = 21;
    localparam int FRAC_Q_W    = 21;
    localparam int OUT_DATA_W  = 130;
    localparam int OUT_TDATA_W = 136;
    localparam int MICRO       = 1000000;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        hour;
        logic [7:0]        minute;
        logic [7:0]        second;
        logic [7:0]        day;
        logic signed [8:0] month;
        logic [8:0]        year;
    } t_nrmc_clock;

    function automatic longint unsigned pow10(input int n);
        longint unsigned r;
        r = 1;
        for (int i = 0; i < n; i++) begin
            r = r * 10;
        end
        return r;
    endfunction

    function automatic int minute_width(input int fd);
        return $clog2(64'd100 * pow10(fd));
    endfunction

    function automatic int speed_width(input int fd);
        return $clog2(64'd1000 * pow10(fd));
    endfunction

    function automatic logic [7:0] two_digit(input logic [3:0] tens, input logic [3:0] units);
        return 8'(tens) * 8'd10 + 8'(units);
    endfunction

endpackage

>>> hw/rtl/nrmc_cdiv.sv
// Pipelined multiply by A and divide by constant B (floor), three register stages.
// Depends on nothing but its parameters; used for minutes and speed scaling.
module nrmc_cdiv #(
    parameter int XW = 20,
    parameter int A  = 5,
    parameter int B  = 3,
    parameter int QW = 21
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [XW-1:0] i_x,
    output logic [QW-1:0] o_q
);

    localparam int AW  = $clog2(A + 1);
    localparam int YW  = XW + AW;
    localparam int BW  = $clog2(B + 1);
    localparam int S   = YW + BW;
    localparam int RW  = YW + 1;
    localparam int PW  = YW + RW;
    localparam int QOW = PW - S;
    localparam logic [63:0]   RECIP_FULL = (64'd1 << S) / 64'(B);
    localparam logic [RW-1:0] RECIP      = RECIP_FULL[RW-1:0];

    logic [YW-1:0]  r_y;
    logic [YW-1:0]  r_y2;
    logic [PW-1:0]  r_prod;
    logic [QOW-1:0] r_q0;
    logic           r_ge;
    logic [QOW-1:0] q0;
    logic [YW-1:0]  qb;
    logic [YW-1:0]  rem;

    // reciprocal estimate is low by at most one
    assign q0  = r_prod[PW-1:S];
    assign qb  = YW'(q0) * YW'(B);
    assign rem = r_y2 - qb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y    <= YW'(i_x) * YW'(A);
            r_y2   <= r_y;
            r_prod <= PW'(r_y) * PW'(RECIP);
            r_q0   <= q0;
            r_ge   <= (rem >= YW'(B));
        end
    end

    assign o_q = QW'(r_q0) + QW'(r_ge);

endmodule

>>> hw/rtl/nrmc_parse.sv
// Character parser: field splitting, digit accumulation and end-of-sentence snapshot.
// Depends on nrmc_pkg.
module nrmc_parse
    import nrmc_pkg::*;
#(
    parameter int MINUTE_FRACTION_DIGITS = MINUTE_FRACTION_DIGITS_DEF,
    parameter int SPEED_FRACTION_DIGITS  = SPEED_FRACTION_DIGITS_DEF,
    localparam int MinW = minute_width(MINUTE_FRACTION_DIGITS),
    localparam int SpdW = speed_width(SPEED_FRACTION_DIGITS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic [7:0]      i_char,
    input  logic            i_eos,
    output t_nrmc_clock     o_clock,
    output logic [6:0]      o_lat_deg,
    output logic [MinW-1:0] o_lat_min,
    output logic            o_lat_north,
    output logic [9:0]      o_lon_deg,
    output logic [MinW-1:0] o_lon_min,
    output logic            o_lon_east,
    output logic [SpdW-1:0] o_speed
);

    localparam int FW = (MinW > SpdW) ? MinW : SpdW;
    localparam int PW = FW + 24;
    localparam int TW = FW + 4;
    localparam logic [FW-1:0] MIN_CAP = FW'(64'd100 * pow10(MINUTE_FRACTION_DIGITS) - 64'd1);
    localparam logic [FW-1:0] SPD_CAP = FW'(64'd1000 * pow10(SPEED_FRACTION_DIGITS) - 64'd1);
    localparam logic [2:0] MIN_FD = 3'(MINUTE_FRACTION_DIGITS);
    localparam logic [2:0] SPD_FD = 3'(SPEED_FRACTION_DIGITS);

    localparam logic [1:0] PH_INT  = 2'd0;
    localparam logic [1:0] PH_FRAC = 2'd1;
    localparam logic [1:0] PH_STOP = 2'd2;

    localparam logic [4:0] LEN_MAX     = 5'd31;
    localparam logic [4:0] TIME_LEN_OK = 5'd10;
    localparam logic [4:0] DATE_LEN_OK = 5'd6;
    localparam logic [4:0] HDR_LEN     = 5'd6;

    logic [3:0]      r_field,      n_field;
    logic [4:0]      r_pos,        n_pos;
    logic            r_hdr_ok,     n_hdr_ok;
    logic [3:0]      r_time_dig [0:5];
    logic [3:0]      n_time_dig [0:5];
    logic [3:0]      r_date_dig [0:5];
    logic [3:0]      n_date_dig [0:5];
    logic [4:0]      r_time_len,   n_time_len;
    logic [4:0]      r_date_len,   n_date_len;
    logic [7:0]      r_status_chr, n_status_chr;
    logic [6:0]      r_lat_deg,    n_lat_deg;
    logic [MinW-1:0] r_lat_min,    n_lat_min;
    logic            r_lat_north,  n_lat_north;
    logic [9:0]      r_lon_deg,    n_lon_deg;
    logic [MinW-1:0] r_lon_min,    n_lon_min;
    logic            r_lon_east,   n_lon_east;
    logic [SpdW-1:0] r_speed,      n_speed;
    logic [2:0]      r_frac_cnt,   n_frac_cnt;
    logic [1:0]      r_phase,      n_phase;

    logic            is_digit;
    logic [3:0]      digit;
    logic [FW-1:0]   sel_v;
    logic [FW-1:0]   sel_cap;
    logic [2:0]      sel_fd;
    logic [2:0]      fin_k;
    logic [PW-1:0]   fin_prod;
    logic [FW-1:0]   fin_val;
    logic [TW-1:0]   feed_t;
    logic [FW-1:0]   feed_v;
    logic [1:0]      feed_phase;
    logic [2:0]      feed_cnt;
    logic            ok_a;
    logic            reject;
    t_nrmc_clock     n_clock;

    assign is_digit = i_char inside {[CH_ZERO:CH_NINE]};
    assign digit    = is_digit ? i_char[3:0] : 4'd0;

    // shared number unit: one of minutes or speed is active at a time
    always_comb begin
        sel_v   = '0;
        sel_cap = MIN_CAP;
        sel_fd  = MIN_FD;
        case (r_field)
            FLD_LAT:   sel_v = FW'(r_lat_min);
            FLD_LON:   sel_v = FW'(r_lon_min);
            FLD_SPEED: begin
                sel_v   = FW'(r_speed);
                sel_cap = SPD_CAP;
                sel_fd  = SPD_FD;
            end
            default:   sel_v = '0;
        endcase
    end

    // pad missing fraction digits at the closing comma, saturate
    assign fin_k    = sel_fd - r_frac_cnt;
    assign fin_prod = PW'(sel_v) * PW'(POW10_TAB[fin_k]);
    assign fin_val  = (fin_prod > PW'(sel_cap)) ? sel_cap : fin_prod[FW-1:0];

    assign feed_t = TW'(sel_v) * TW'(10) + TW'(digit);

    always_comb begin
        feed_v     = sel_v;
        feed_phase = r_phase;
        feed_cnt   = r_frac_cnt;
        if (r_phase != PH_STOP) begin
            if (is_digit) begin
                if (r_phase == PH_INT || r_frac_cnt < sel_fd) begin
                    feed_v = (feed_t > TW'(sel_cap)) ? sel_cap : feed_t[FW-1:0];
                    if (r_phase == PH_FRAC) begin
                        feed_cnt = r_frac_cnt + 3'd1;
                    end
                end
            end else if (i_char == CH_POINT && r_phase == PH_INT) begin
                feed_phase = PH_FRAC;
            end else begin
                feed_phase = PH_STOP;
            end
        end
    end

    always_comb begin
        n_field      = r_field;
        n_pos        = r_pos;
        n_hdr_ok     = r_hdr_ok;
        n_time_dig   = r_time_dig;
        n_date_dig   = r_date_dig;
        n_time_len   = r_time_len;
        n_date_len   = r_date_len;
        n_status_chr = r_status_chr;
        n_lat_deg    = r_lat_deg;
        n_lat_min    = r_lat_min;
        n_lat_north  = r_lat_north;
        n_lon_deg    = r_lon_deg;
        n_lon_min    = r_lon_min;
        n_lon_east   = r_lon_east;
        n_speed      = r_speed;
        n_frac_cnt   = r_frac_cnt;
        n_phase      = r_phase;
        if (i_char == CH_COMMA && r_field < LAST_FIELD) begin
            if (r_field == FLD_HEADER && r_pos < HDR_LEN) begin
                n_hdr_ok = 1'b0;
            end
            case (r_field)
                FLD_LAT:   n_lat_min = fin_val[MinW-1:0];
                FLD_LON:   n_lon_min = fin_val[MinW-1:0];
                FLD_SPEED: n_speed   = fin_val[SpdW-1:0];
                default:   n_speed   = r_speed;
            endcase
            n_field    = r_field + 4'd1;
            n_pos      = 5'd0;
            n_phase    = PH_INT;
            n_frac_cnt = 3'd0;
        end else begin
            case (r_field)
                FLD_HEADER: begin
                    if (r_pos < HDR_LEN && i_char != HDR_TEXT[r_pos[2:0]]) begin
                        n_hdr_ok = 1'b0;
                    end
                end
                FLD_TIME: begin
                    if (r_pos < 5'd6) begin
                        n_time_dig[r_pos[2:0]] = i_char[3:0];
                    end
                    if (r_time_len != LEN_MAX) begin
                        n_time_len = r_time_len + 5'd1;
                    end
                end
                FLD_STATUS: begin
                    if (r_pos == 5'd0) begin
                        n_status_chr = i_char;
                    end
                end
                FLD_LAT: begin
                    if (r_pos < 5'd2) begin
                        n_lat_deg = r_lat_deg * 7'd10 + 7'(digit);
                    end else begin
                        n_lat_min  = feed_v[MinW-1:0];
                        n_phase    = feed_phase;
                        n_frac_cnt = feed_cnt;
                    end
                end
                FLD_NS: begin
                    if (r_pos == 5'd0) begin
                        n_lat_north = (i_char == CH_N);
                    end
                end
                FLD_LON: begin
                    if (r_pos < 5'd3) begin
                        n_lon_deg = r_lon_deg * 10'd10 + 10'(digit);
                    end else begin
                        n_lon_min  = feed_v[MinW-1:0];
                        n_phase    = feed_phase;
                        n_frac_cnt = feed_cnt;
                    end
                end
                FLD_EW: begin
                    if (r_pos == 5'd0) begin
                        n_lon_east = (i_char == CH_E);
                    end
                end
                FLD_SPEED: begin
                    n_speed    = feed_v[SpdW-1:0];
                    n_phase    = feed_phase;
                    n_frac_cnt = feed_cnt;
                end
                FLD_DATE: begin
                    if (r_pos < 5'd6) begin
                        n_date_dig[r_pos[2:0]] = i_char[3:0];
                    end
                    if (r_date_len != LEN_MAX) begin
                        n_date_len = r_date_len + 5'd1;
                    end
                end
                default: n_pos = r_pos;
            endcase
            if (r_pos != LEN_MAX) begin
                n_pos = r_pos + 5'd1;
            end
        end
    end

    // return to start of sentence after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_eos)) begin
            r_field      <= 4'd0;
            r_pos        <= 5'd0;
            r_hdr_ok     <= 1'b1;
            r_time_dig   <= '{default: 4'd0};
            r_date_dig   <= '{default: 4'd0};
            r_time_len   <= 5'd0;
            r_date_len   <= 5'd0;
            r_status_chr <= 8'd0;
            r_lat_deg    <= 7'd0;
            r_lat_min    <= '0;
            r_lat_north  <= 1'b0;
            r_lon_deg    <= 10'd0;
            r_lon_min    <= '0;
            r_lon_east   <= 1'b0;
            r_speed      <= '0;
            r_frac_cnt   <= 3'd0;
            r_phase      <= PH_INT;
        end else if (i_go) begin
            r_field      <= n_field;
            r_pos        <= n_pos;
            r_hdr_ok     <= n_hdr_ok;
            r_time_dig   <= n_time_dig;
            r_date_dig   <= n_date_dig;
            r_time_len   <= n_time_len;
            r_date_len   <= n_date_len;
            r_status_chr <= n_status_chr;
            r_lat_deg    <= n_lat_deg;
            r_lat_min    <= n_lat_min;
            r_lat_north  <= n_lat_north;
            r_lon_deg    <= n_lon_deg;
            r_lon_min    <= n_lon_min;
            r_lon_east   <= n_lon_east;
            r_speed      <= n_speed;
            r_frac_cnt   <= n_frac_cnt;
            r_phase      <= n_phase;
        end
    end

    assign ok_a   = (n_status_chr == CH_A);
    assign reject = (n_field < LAST_FIELD) || !n_hdr_ok ||
                    (!ok_a && (n_time_len != TIME_LEN_OK || n_date_len != DATE_LEN_OK));

    // time and date of the finished sentence; all zero but the status when rejected
    always_comb begin
        n_clock = '0;
        if (reject) begin
            n_clock.status = FIX_REJECT;
        end else begin
            n_clock.status = ok_a ? FIX_VALID : FIX_VOID;
            n_clock.hour   = two_digit(n_time_dig[0], n_time_dig[1]);
            n_clock.minute = two_digit(n_time_dig[2], n_time_dig[3]);
            n_clock.second = two_digit(n_time_dig[4], n_time_dig[5]);
            n_clock.day    = two_digit(n_date_dig[0], n_date_dig[1]);
            n_clock.month  = $signed(9'(two_digit(n_date_dig[2], n_date_dig[3])) - 9'd1);
            n_clock.year   = 9'(two_digit(n_date_dig[4], n_date_dig[5])) + 9'd100;
        end
    end

    // snapshot of the finished sentence; position only for a valid fix
    always_ff @(posedge i_clk) begin
        if (i_go && i_eos) begin
            o_clock <= n_clock;
            if (ok_a && !reject) begin
                o_lat_deg   <= n_lat_deg;
                o_lat_min   <= n_lat_min;
                o_lat_north <= n_lat_north;
                o_lon_deg   <= n_lon_deg;
                o_lon_min   <= n_lon_min;
                o_lon_east  <= n_lon_east;
                o_speed     <= n_speed;
            end else begin
                o_lat_deg   <= 7'd0;
                o_lat_min   <= '0;
                o_lat_north <= 1'b1;
                o_lon_deg   <= 10'd0;
                o_lon_min   <= '0;
                o_lon_east  <= 1'b1;
                o_speed     <= '0;
            end
        end
    end

endmodule

>>> hw/rtl/nmea_rmc_sentence_parser.sv
// Top level of the RMC sentence parser: input register, parser, scaling pipeline, result register.
// Depends on nrmc_pkg, nrmc_parse, nrmc_cdiv and nmea_rmc_sentence_parser_assert.svh.
//
// Usage:
//   Input stream: one character per item in i_s_tdata, i_s_tlast high on the
//   final character of the sentence. Every byte is data.
//   Output stream: one result item per sentence, given for the item that
//   carried i_s_tlast. o_m_tuser holds the fix status (valid, void, rejected);
//   o_m_tdata holds time, date, latitude, longitude and speed.
// Result path: the final character goes from the input register through the
//   parser snapshot, three scaling stages and the result register; the
//   pipeline holds while the receiver stalls.
// Throughput: one character per cycle, back to back, sentences included, but a final character
//   waits while the result register stalls; the cost of a result is set by the pipelined
//   multiply-by-reciprocal units that turn minutes into microdegrees and knots into km/h.
// Reset: i_rst_n low at a clock edge empties every stage and puts the parser
//   back at the start of a sentence.
// Stall: while the result register waits, characters other than the final
//   one keep being accepted and parsed; a final character is held in the
//   input register until the scaling pipeline moves again.
`include "nmea_rmc_sentence_parser_assert.svh"

module nmea_rmc_sentence_parser
    import nrmc_pkg::*;
#(
    parameter int MINUTE_FRACTION_DIGITS = MINUTE_FRACTION_DIGITS_DEF,
    parameter int SPEED_FRACTION_DIGITS  = SPEED_FRACTION_DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,  // [7:0] char_in
    input  logic                   i_s_tlast,  // end_of_sentence
    // master side
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [7:0] hour_value, [15:8] minute_value, [23:16] second_value,
    // [31:24] day_value, [40:32] month_from_zero, [49:41] years_since_1900,
    // [77:50] latitude_microdeg, [108:78] longitude_microdeg,
    // [129:109] speed_milli_kmh, [135:130] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [1:0]             o_m_tuser   // [1:0] fix_status
);

    localparam int MinW = minute_width(MINUTE_FRACTION_DIGITS);
    localparam int SpdW = speed_width(SPEED_FRACTION_DIGITS);

    // minutes/60 to millionths of a degree reduces to x * MinA / MinB
    localparam int MinG = (MINUTE_FRACTION_DIGITS <= 4) ? 20 :
                          (MINUTE_FRACTION_DIGITS == 5) ? 10 : 1;
    localparam int MinA = int'(pow10(6 - MINUTE_FRACTION_DIGITS) / MinG);
    localparam int MinB = 60 / MinG;
    // knots to km/h: x * 1852 / 10^digits, reduced
    localparam int SpdG = (SPEED_FRACTION_DIGITS >= 2) ? 4 : 2;
    localparam int SpdA = 1852 / SpdG;
    localparam int SpdB = int'(pow10(SPEED_FRACTION_DIGITS) / SpdG);

    // input register
    logic            r_in_valid;
    logic [7:0]      r_in_char;
    logic            r_in_eos;
    logic            in_go;
    logic            res_en;

    // result pipeline valids
    logic            r_v1, r_v2, r_v3, r_v4;
    logic            r_out_valid;

    // parser snapshot
    t_nrmc_clock     snap_clock;
    logic [6:0]      snap_lat_deg;
    logic [MinW-1:0] snap_lat_min;
    logic            snap_lat_north;
    logic [9:0]      snap_lon_deg;
    logic [MinW-1:0] snap_lon_min;
    logic            snap_lon_east;
    logic [SpdW-1:0] snap_speed;

    // delay line alongside the scaling units
    t_nrmc_clock     r_clock2, r_clock3, r_clock4;
    logic [LAT_W-1:0] r_lat_degm2, r_lat_degm3, r_lat_degm4;
    logic [LON_W-1:0] r_lon_degm2, r_lon_degm3, r_lon_degm4;
    logic            r_lat_n2, r_lat_n3, r_lat_n4;
    logic            r_lon_e2, r_lon_e3, r_lon_e4;

    logic [FRAC_Q_W-1:0] lat_q;
    logic [FRAC_Q_W-1:0] lon_q;
    logic [SPEED_W-1:0]  spd_q;
    logic [LAT_W-1:0]    lat_abs;
    logic [LON_W-1:0]    lon_abs;

    // result register
    t_nrmc_clock         r_out_clock;
    logic signed [LAT_W-1:0] r_out_lat;
    logic signed [LON_W-1:0] r_out_lon;
    logic [SPEED_W-1:0]  r_out_speed;

    // the whole result pipeline moves together whenever the result register frees
    assign res_en     = !r_out_valid || i_m_tready;
    // ordinary characters never wait; the final one needs the pipeline to move
    assign in_go      = r_in_valid && (!r_in_eos || res_en);
    assign o_s_tready = !r_in_valid || in_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_tdata;
            r_in_eos  <= i_s_tlast;
        end
    end

    nrmc_parse #(
        .MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS),
        .SPEED_FRACTION_DIGITS (SPEED_FRACTION_DIGITS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (in_go),
        .i_char     (r_in_char),
        .i_eos      (r_in_eos),
        .o_clock    (snap_clock),
        .o_lat_deg  (snap_lat_deg),
        .o_lat_min  (snap_lat_min),
        .o_lat_north(snap_lat_north),
        .o_lon_deg  (snap_lon_deg),
        .o_lon_min  (snap_lon_min),
        .o_lon_east (snap_lon_east),
        .o_speed    (snap_speed)
    );

    nrmc_cdiv #(.XW(MinW), .A(MinA), .B(MinB), .QW(FRAC_Q_W)) u_lat_div (
        .i_clk(i_clk),
        .i_en (res_en),
        .i_x  (snap_lat_min),
        .o_q  (lat_q)
    );

    nrmc_cdiv #(.XW(MinW), .A(MinA), .B(MinB), .QW(FRAC_Q_W)) u_lon_div (
        .i_clk(i_clk),
        .i_en (res_en),
        .i_x  (snap_lon_min),
        .o_q  (lon_q)
    );

    nrmc_cdiv #(.XW(SpdW), .A(SpdA), .B(SpdB), .QW(SPEED_W)) u_spd_div (
        .i_clk(i_clk),
        .i_en (res_en),
        .i_x  (snap_speed),
        .o_q  (spd_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (res_en) begin
            r_v1        <= in_go && r_in_eos;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= r_v4;
        end
    end

    // whole degrees scaled here, in step with the divider stages
    always_ff @(posedge i_clk) begin
        if (res_en) begin
            r_clock2    <= snap_clock;
            r_lat_degm2 <= LAT_W'(snap_lat_deg) * LAT_W'(MICRO);
            r_lon_degm2 <= LON_W'(snap_lon_deg) * LON_W'(MICRO);
            r_lat_n2    <= snap_lat_north;
            r_lon_e2    <= snap_lon_east;
            r_clock3    <= r_clock2;
            r_lat_degm3 <= r_lat_degm2;
            r_lon_degm3 <= r_lon_degm2;
            r_lat_n3    <= r_lat_n2;
            r_lon_e3    <= r_lon_e2;
            r_clock4    <= r_clock3;
            r_lat_degm4 <= r_lat_degm3;
            r_lon_degm4 <= r_lon_degm3;
            r_lat_n4    <= r_lat_n3;
            r_lon_e4    <= r_lon_e3;
        end
    end

    assign lat_abs = r_lat_degm4 + LAT_W'(lat_q);
    assign lon_abs = r_lon_degm4 + LON_W'(lon_q);

    // south and west are negative
    always_ff @(posedge i_clk) begin
        if (res_en) begin
            r_out_clock <= r_clock4;
            r_out_lat   <= $signed(r_lat_n4 ? lat_abs : (~lat_abs + LAT_W'(1)));
            r_out_lon   <= $signed(r_lon_e4 ? lon_abs : (~lon_abs + LON_W'(1)));
            r_out_speed <= spd_q;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_clock.status;
    assign o_m_tdata  = {
        (OUT_TDATA_W - OUT_DATA_W)'(0),
        r_out_speed,
        r_out_lon,
        r_out_lat,
        r_out_clock.year,
        r_out_clock.month,
        r_out_clock.day,
        r_out_clock.second,
        r_out_clock.minute,
        r_out_clock.hour
    };

    `NRMC_ASSERT_NEXT(a_eos_held, i_clk, i_rst_n,
        r_in_valid && r_in_eos && !res_en, r_in_valid && r_in_eos,
        "final character left the input register while the pipeline was frozen")

    `NRMC_ASSERT_NEXT(a_pipe_frozen, i_clk, i_rst_n,
        !res_en, $stable({r_v1, r_v2, r_v3, r_v4}),
        "result pipeline moved while the result register was stalled")

    `NRMC_ASSERT_SAME(a_no_fix_no_pos, i_clk, i_rst_n,
        r_out_valid && (r_out_clock.status != FIX_VALID),
        (r_out_lat == '0) && (r_out_lon == '0) && (r_out_speed == '0),
        "position or speed given without a valid fix")

    `NRMC_ASSERT_SAME(a_reject_zero, i_clk, i_rst_n,
        r_out_valid && (r_out_clock.status == FIX_REJECT),
        (r_out_clock.hour == 8'd0) && (r_out_clock.day == 8'd0) &&
        (r_out_clock.month == 9'sd0) && (r_out_clock.year == 9'd0),
        "rejected sentence carries time or date")

endmodule
